@@ design/ladder_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the four-pole ladder lowpass core.
// Holds the multiplier request struct and the divider request/response structs; no dependencies.
package ladder_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_A_BITS = 34;
    localparam int MUL_B_BITS = 32;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    // Iterative divider widths
    localparam int DIV_N_BITS = 64;
    localparam int DIV_D_BITS = 32;

    // Configuration port widths
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic signed [MUL_A_BITS-1:0] mul_a_t;
    typedef logic signed [MUL_B_BITS-1:0] mul_b_t;
    typedef logic signed [MUL_P_BITS-1:0] mul_p_t;

    typedef struct packed {
        mul_a_t a;
        mul_b_t b;
    } mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_N_BITS-1:0] dividend;
        logic [DIV_D_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_N_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

@@ design/ladder_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on ladder_pkg for operand and product types.
module ladder_mul (
    input  logic                 clk,
    input  ladder_pkg::mul_req_t req,
    output ladder_pkg::mul_p_t   prod
);
    import ladder_pkg::*;

    mul_p_t prod_reg;

    // One product per cycle, available the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p_t'(req.a) * mul_p_t'(req.b);
    end

    assign prod = prod_reg;

endmodule

@@ design/ladder_div.sv @@
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on ladder_pkg for the request/response structs.
module ladder_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ladder_pkg::div_req_t req,
    output ladder_pkg::div_rsp_t rsp
);
    import ladder_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_N_BITS + 1);
    localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(DIV_N_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(1);

    logic [DIV_N_BITS-1:0] quo_reg;
    logic [DIV_D_BITS-1:0] rem_reg;
    logic [DIV_D_BITS-1:0] divisor_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  done_reg;

    logic [DIV_D_BITS:0]   rem_shift;
    logic                  fits;

    // Trial subtract of the shifted remainder
    assign rem_shift = {rem_reg, quo_reg[DIV_N_BITS-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    // Sequencing: count down the steps, flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= STEPS;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - LAST_STEP;
                done_reg <= (cnt_reg == LAST_STEP);
            end
        end
    end

    // Datapath: dividend shifts out on top, quotient bits shift in below
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_N_BITS-2:0], fits};
            rem_reg <= fits ? DIV_D_BITS'(rem_shift - {1'b0, divisor_reg})
                            : rem_shift[DIV_D_BITS-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ design/four_pole_ladder_lowpass_core.sv @@
`timescale 1ns / 1ps
// Top level of the four-pole ladder lowpass with tanh feedback.
// Depends on ladder_pkg, ladder_mul and ladder_div; holds the sequencer and tanh table.
//
// Four one-pole lowpass stages in Q5.27 with a tanh feedback path through a
// one-zero highpass. One sample request is worked through a single shared
// multiplier under a small sequencer; the table read and interpolation states
// are skipped when the tanh argument is at or beyond plus or minus 4.
// sample_ready stays low while a sample is in work, and the output state
// waits while a previous result is still not taken. After reset the tanh
// table (TANH_TABLE_ENTRIES+1 points) is computed in place, using the shared
// multiplier and a bit-serial 64-step divider; no sample is accepted until
// it is done. Configuration writes are taken at any time, one per cycle;
// register 0 is cutoff_gain (Q0.16), register 1 is feedback_gain (Q2.14),
// other indexes are ignored. Write them only while the block is idle.
module four_pole_ladder_lowpass_core #(
    parameter int SAMPLE_BITS        = 24,
    parameter int TANH_TABLE_ENTRIES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [SAMPLE_BITS-1:0]         sample_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ladder_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ladder_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ladder_pkg::*;

    typedef logic signed [31:0] stage_t;

    localparam int ADDR_BITS = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int SH_UP     = (SAMPLE_BITS <= 28) ? 28 - SAMPLE_BITS : 0;
    localparam int SH_DN     = (SAMPLE_BITS > 28) ? SAMPLE_BITS - 28 : 0;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF_GAIN   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = CFG_INDEX_BITS'(1);
    localparam logic [15:0] CUTOFF_GAIN_RESET   = 16'd7584;
    localparam logic [15:0] FEEDBACK_GAIN_RESET = 16'd0;

    // Fixed-point constants
    localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [35:0] FOUR_Q27    = 36'sd536870912;
    localparam stage_t             ONE_Q27     = 32'sd134217728;
    localparam stage_t             FOUR_Q27_32 = 32'sd536870912;
    localparam int                 HP_POLE_Q16 = 65339;
    localparam logic signed [35:0] STAGE_MAX   = 36'sd2147483647;
    localparam logic signed [35:0] STAGE_MIN   = -36'sd2147483648;
    localparam logic signed [35:0] OUT_MAX     = (36'sd1 <<< (SAMPLE_BITS - 1)) - 36'sd1;
    localparam logic signed [35:0] OUT_MIN     = -(36'sd1 <<< (SAMPLE_BITS - 1));

    localparam logic [3:0] SERIES_TERMS = 4'd12;
    localparam logic [1:0] LAST_SQUARE  = 2'd3;
    localparam logic [1:0] FIRST_STAGE  = 2'd0;
    localparam logic [1:0] LAST_STAGE   = 2'd3;
    localparam logic [ADDR_BITS-1:0] TABLE_LAST = ADDR_BITS'(TANH_TABLE_ENTRIES);
    localparam logic [ADDR_BITS-1:0] IDX_LAST   = ADDR_BITS'(TANH_TABLE_ENTRIES - 1);

    // Sequencer states: table build, then per-sample work
    localparam logic [4:0] ST_BX   = 5'd0;
    localparam logic [4:0] ST_BXW  = 5'd1;
    localparam logic [4:0] ST_BTM  = 5'd2;
    localparam logic [4:0] ST_BTD  = 5'd3;
    localparam logic [4:0] ST_BTW  = 5'd4;
    localparam logic [4:0] ST_BCL  = 5'd5;
    localparam logic [4:0] ST_BSM  = 5'd6;
    localparam logic [4:0] ST_BSU  = 5'd7;
    localparam logic [4:0] ST_BFD  = 5'd8;
    localparam logic [4:0] ST_BFW  = 5'd9;
    localparam logic [4:0] ST_IDLE = 5'd10;
    localparam logic [4:0] ST_POS  = 5'd11;
    localparam logic [4:0] ST_IDX  = 5'd12;
    localparam logic [4:0] ST_RD1  = 5'd13;
    localparam logic [4:0] ST_RD2  = 5'd14;
    localparam logic [4:0] ST_INT  = 5'd15;
    localparam logic [4:0] ST_HPM  = 5'd16;
    localparam logic [4:0] ST_HPU  = 5'd17;
    localparam logic [4:0] ST_STM  = 5'd18;
    localparam logic [4:0] ST_STU  = 5'd19;
    localparam logic [4:0] ST_OUT  = 5'd20;

    function automatic stage_t sat32(input logic signed [35:0] v);
        if (v > STAGE_MAX)
        begin
            return stage_t'(STAGE_MAX);
        end
        if (v < STAGE_MIN)
        begin
            return stage_t'(STAGE_MIN);
        end
        return stage_t'(v);
    endfunction

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic [15:0] cutoff_gain_reg;
    logic [15:0] feedback_gain_reg;

    // Filter state; stage_reg rotates during the update so slot 0 is the one at work
    stage_t stage_reg [0:3];
    stage_t fmem_reg;

    // Per-sample working registers
    stage_t                x_reg;
    stage_t                fb_reg;
    stage_t                prev_reg;
    stage_t                t0_reg;
    logic signed [33:0]    drive_reg;
    logic [ADDR_BITS-1:0]  idx_reg;
    logic [29:0]           frac_reg;
    logic [1:0]            j_reg;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    logic [SAMPLE_BITS-1:0] sample_out_reg;

    // Table build working registers
    logic [ADDR_BITS-1:0]  pt_reg;
    logic                  xneg_reg;
    logic [29:0]           abs_reg;
    logic [30:0]           term_reg;
    logic signed [32:0]    e_reg;
    logic [3:0]            n_reg;
    logic [1:0]            sq_reg;

    // Tanh table memory
    stage_t                tanh_mem [0:TANH_TABLE_ENTRIES];
    stage_t                rdata_reg;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  mem_we;
    stage_t                mem_wdata;

    mul_req_t mul_req;
    mul_p_t   prod;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Combinational helpers
    logic signed [35:0]    tanh_arg;
    logic                  arg_low;
    logic                  arg_high;
    logic [15:0]           idx_wide;
    logic [ADDR_BITS-1:0]  idx_sel;
    logic signed [35:0]    interp;
    stage_t                fb_interp;
    stage_t                hp_mem;
    logic signed [33:0]    drive_val;
    logic signed [33:0]    stage_target;
    logic signed [33:0]    stage_diff;
    logic [16:0]           stage_gain;
    stage_t                stage_sum;
    stage_t                x_in;
    logic signed [35:0]    y_wide;
    logic signed [35:0]    y_sat;
    logic                  out_free;
    stage_t                pt_x;
    logic [29:0]           pt_abs;
    logic [30:0]           term_new;
    logic signed [32:0]    e_clamped;
    stage_t                t_val;

    ladder_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    ladder_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Per-sample arithmetic around the shared product
    assign tanh_arg  = 36'(prod >>> 14);
    assign arg_low   = tanh_arg <= -FOUR_Q27;
    assign arg_high  = tanh_arg >= FOUR_Q27;
    assign idx_wide  = prod[45:30];
    assign idx_sel   = (idx_wide >= 16'(TANH_TABLE_ENTRIES)) ? IDX_LAST
                                                              : idx_wide[ADDR_BITS-1:0];
    assign interp    = 36'(t0_reg) + 36'(prod >>> 30);
    assign fb_interp = stage_t'(interp >>> 3);
    assign hp_mem    = sat32(36'(prod >>> 16));
    assign drive_val = 34'(x_reg) - 34'(fb_reg) + 34'(fmem_reg);

    assign stage_target = (j_reg == FIRST_STAGE) ? drive_reg : 34'(prev_reg);
    assign stage_diff   = stage_target - 34'(stage_reg[0]);
    assign stage_gain   = (j_reg == FIRST_STAGE) ? {cutoff_gain_reg, 1'b0}
                                                 : {1'b0, cutoff_gain_reg};
    assign stage_sum    = sat32(36'(stage_reg[0]) + 36'(prod >>> 16));

    // Sample format conversions
    assign x_in   = stage_t'((36'(sample_in) <<< SH_UP) >>> SH_DN);
    assign y_wide = (36'(stage_reg[3]) >>> SH_UP) <<< SH_DN;
    assign y_sat  = (y_wide > OUT_MAX) ? OUT_MAX : ((y_wide < OUT_MIN) ? OUT_MIN : y_wide);

    // Table build arithmetic around the divider result
    assign pt_x      = $signed(div_rsp.quotient[31:0]) - FOUR_Q27_32;
    assign pt_abs    = (pt_x < 0) ? 30'(-pt_x) : 30'(pt_x);
    assign term_new  = div_rsp.quotient[30:0];
    assign e_clamped = (e_reg < 0) ? 33'sd0 : ((e_reg > ONE_Q30) ? ONE_Q30 : e_reg);
    assign t_val     = $signed({1'b0, div_rsp.quotient[30:0]});
    assign mem_wdata = xneg_reg ? -t_val : t_val;
    assign mem_we    = (state_reg == ST_BFW) && div_rsp.done;
    assign rd_addr   = (state_reg == ST_RD1) ? idx_reg + ADDR_BITS'(1) : idx_sel;

    assign out_free = !result_valid_reg || result_ready;

    // Shared multiplier operand select
    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_req.a = mul_a_t'({18'b0, feedback_gain_reg});
                mul_req.b = stage_reg[3];
            end
            ST_POS:
            begin
                mul_req.a = mul_a_t'(tanh_arg + FOUR_Q27);
                mul_req.b = mul_b_t'(TANH_TABLE_ENTRIES);
            end
            ST_RD2:
            begin
                mul_req.a = 34'(rdata_reg) - 34'(t0_reg);
                mul_req.b = mul_b_t'({2'b0, frac_reg});
            end
            ST_HPM:
            begin
                mul_req.a = mul_a_t'(fb_reg);
                mul_req.b = mul_b_t'(HP_POLE_Q16);
            end
            ST_STM:
            begin
                mul_req.a = stage_diff;
                mul_req.b = mul_b_t'({15'b0, stage_gain});
            end
            ST_BTM:
            begin
                mul_req.a = mul_a_t'({3'b0, term_reg});
                mul_req.b = mul_b_t'({2'b0, abs_reg});
            end
            ST_BSM:
            begin
                mul_req.a = mul_a_t'(e_reg);
                mul_req.b = mul_b_t'(e_reg);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    // Divider request select
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            ST_BX:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_BITS'({pt_reg, 30'b0});
                div_req.divisor  = DIV_D_BITS'(TANH_TABLE_ENTRIES);
            end
            ST_BTD:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_BITS'(prod[MUL_P_BITS-1:30]);
                div_req.divisor  = DIV_D_BITS'(n_reg);
            end
            ST_BFD:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_BITS'({31'(ONE_Q30 - e_reg), 30'b0});
                div_req.divisor  = DIV_D_BITS'(ONE_Q30 + e_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BX:   state_next = ST_BXW;
            ST_BXW:  state_next = div_rsp.done ? ST_BTM : ST_BXW;
            ST_BTM:  state_next = ST_BTD;
            ST_BTD:  state_next = ST_BTW;
            ST_BTW:
            begin
                if (div_rsp.done)
                begin
                    state_next = (n_reg == SERIES_TERMS) ? ST_BCL : ST_BTM;
                end
            end
            ST_BCL:  state_next = ST_BSM;
            ST_BSM:  state_next = ST_BSU;
            ST_BSU:  state_next = (sq_reg == LAST_SQUARE) ? ST_BFD : ST_BSM;
            ST_BFD:  state_next = ST_BFW;
            ST_BFW:
            begin
                if (div_rsp.done)
                begin
                    state_next = (pt_reg == TABLE_LAST) ? ST_IDLE : ST_BX;
                end
            end
            ST_IDLE: state_next = sample_valid ? ST_POS : ST_IDLE;
            ST_POS:  state_next = (arg_low || arg_high) ? ST_HPM : ST_IDX;
            ST_IDX:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_INT;
            ST_INT:  state_next = ST_HPM;
            ST_HPM:  state_next = ST_HPU;
            ST_HPU:  state_next = ST_STM;
            ST_STM:  state_next = ST_STU;
            ST_STU:  state_next = (j_reg == LAST_STAGE) ? ST_OUT : ST_STM;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_BX;
        endcase
    end

    // Result valid: set when a result loads, cleared when taken
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if ((state_reg == ST_OUT) && out_free)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_BX;
            result_valid_reg  <= 1'b0;
            cutoff_gain_reg   <= CUTOFF_GAIN_RESET;
            feedback_gain_reg <= FEEDBACK_GAIN_RESET;
            stage_reg[0]      <= '0;
            stage_reg[1]      <= '0;
            stage_reg[2]      <= '0;
            stage_reg[3]      <= '0;
            fmem_reg          <= '0;
            pt_reg            <= '0;
            n_reg             <= '0;
            sq_reg            <= '0;
            j_reg             <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CUTOFF_GAIN:   cutoff_gain_reg   <= cfg_data;
                    REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data;
                    default:           ;
                endcase
            end

            case (state_reg)
                ST_BXW:
                begin
                    if (div_rsp.done)
                    begin
                        n_reg <= 4'd1;
                    end
                end
                ST_BTW:
                begin
                    if (div_rsp.done)
                    begin
                        n_reg <= n_reg + 4'd1;
                    end
                end
                ST_BCL:
                begin
                    sq_reg <= '0;
                end
                ST_BSU:
                begin
                    sq_reg <= sq_reg + 2'd1;
                end
                ST_BFW:
                begin
                    if (div_rsp.done && (pt_reg != TABLE_LAST))
                    begin
                        pt_reg <= pt_reg + ADDR_BITS'(1);
                    end
                end
                ST_HPU:
                begin
                    fmem_reg <= hp_mem;
                    j_reg    <= FIRST_STAGE;
                end
                ST_STU:
                begin
                    stage_reg[0] <= stage_reg[1];
                    stage_reg[1] <= stage_reg[2];
                    stage_reg[2] <= stage_reg[3];
                    stage_reg[3] <= stage_sum;
                    j_reg        <= j_reg + 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_BXW:
            begin
                if (div_rsp.done)
                begin
                    xneg_reg <= pt_x < 0;
                    abs_reg  <= pt_abs;
                    term_reg <= 31'(ONE_Q30);
                    e_reg    <= ONE_Q30;
                end
            end
            ST_BTW:
            begin
                if (div_rsp.done)
                begin
                    term_reg <= term_new;
                    // odd terms of the exp(-a) series subtract
                    if (n_reg[0])
                    begin
                        e_reg <= e_reg - $signed({2'b0, term_new});
                    end
                    else
                    begin
                        e_reg <= e_reg + $signed({2'b0, term_new});
                    end
                end
            end
            ST_BCL:
            begin
                e_reg <= e_clamped;
            end
            ST_BSU:
            begin
                e_reg <= 33'(prod >>> 30);
            end
            ST_IDLE:
            begin
                x_reg <= x_in;
            end
            ST_POS:
            begin
                if (arg_low)
                begin
                    fb_reg <= -ONE_Q27;
                end
                else if (arg_high)
                begin
                    fb_reg <= ONE_Q27;
                end
            end
            ST_IDX:
            begin
                idx_reg  <= idx_sel;
                frac_reg <= prod[29:0];
            end
            ST_RD1:
            begin
                t0_reg <= rdata_reg;
            end
            ST_INT:
            begin
                fb_reg <= fb_interp;
            end
            ST_HPU:
            begin
                drive_reg <= drive_val;
            end
            ST_STU:
            begin
                prev_reg <= stage_sum;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    sample_out_reg <= y_sat[SAMPLE_BITS-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Tanh table: written during build, read with a registered port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tanh_mem[pt_reg] <= mem_wdata;
        end
        rdata_reg <= tanh_mem[rd_addr];
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign sample_out   = $signed(sample_out_reg);
    assign cfg_ready    = 1'b1;

endmodule

@@ design/ladder_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the four-pole ladder lowpass core.
// Bound to four_pole_ladder_lowpass_core; no package dependency.
module ladder_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_valid,
    input logic                   sample_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic [SAMPLE_BITS-1:0] sample_out
);

    logic sample_accept;

    assign sample_accept = sample_valid && sample_ready;

    // Nothing offered or taken while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!result_valid && !sample_ready))
        else $error("request handshake active during reset");

    // One sample request in flight at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |=> !sample_ready)
        else $error("second sample request taken while one is in work");

    // A result never appears right after its request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |=> !$rose(result_valid))
        else $error("result appeared one cycle after a sample request");

    // A stalled result holds
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(sample_out)))
        else $error("stalled result dropped or changed");

endmodule

bind four_pole_ladder_lowpass_core ladder_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ladder_checker (.*);
